// ----- src/hsvg_pkg.sv -----
// Package with the constants and helper functions of the HSV to RGB pixel gain unit.
package hsvg_pkg;

    localparam int unsigned STRIP_LENGTH_DEFAULT = 64;

    localparam int unsigned HUE_W    = 9;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned GREEN_W  = 7;
    localparam int unsigned SECTOR_W = 4;
    localparam int unsigned OFFSET_W = 6;

    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned CHAN_MAX    = 255;

    // floor(y / 15) for y below 3840 is (y * 2185) >> 15.
    localparam int unsigned RECIP15_MUL   = 2185;
    localparam int unsigned RECIP15_SHIFT = 15;

    // floor(x / 5) for x below 1024 is (x * 205) >> 10.
    localparam int unsigned RECIP5_MUL   = 205;
    localparam int unsigned RECIP5_SHIFT = 10;

    localparam logic [SECTOR_W-1:0] SEC_RED_UP   = 4'd0;
    localparam logic [SECTOR_W-1:0] SEC_GREEN_DN = 4'd1;
    localparam logic [SECTOR_W-1:0] SEC_GREEN_UP = 4'd2;
    localparam logic [SECTOR_W-1:0] SEC_BLUE_DN  = 4'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLUE_UP  = 4'd4;

    // Sector is the count of 60 degree boundaries at or below the hue.
    function automatic logic [SECTOR_W-1:0] hue_sector(input logic [HUE_W-1:0] hue);
        logic [SECTOR_W-1:0] sec;
        sec = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hue >= HUE_W'(k * SECTOR_SPAN)) begin
                sec = SECTOR_W'(k);
            end
        end
        return sec;
    endfunction

endpackage

// ----- src/hsv_to_rgb_pixel_gain_unit.sv -----
// Top level of the HSV to RGB pixel gain unit: a six stage conversion pipeline.
//
// The unit turns one HSV pixel request into red, green and blue LED levels. A
// request beat is taken at every rising edge where start is high; busy is held
// low because the pipeline never stalls, so one pixel can enter every cycle.
// Each result appears for one cycle, with done high; the receiver cannot
// hold results back and must take every beat when done is high. Results
// leave in request order. The six register stages are: hue split and the
// v*(255-s) product, the divide by 255, the (v-min)*offset product, the
// divide by 60, the sector select, and the fixed channel gains (red 3/5,
// green 2/5, blue unity). All constant divides are done by reciprocal
// multiplies that are exact over their input ranges. A request whose index
// is not below STRIP_LENGTH comes back with written low and zero color
// levels, its index still passed through.
module hsv_to_rgb_pixel_gain_unit #(
    parameter int unsigned STRIP_LENGTH = hsvg_pkg::STRIP_LENGTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hsvg_pkg::INDEX_W-1:0]  pixel_index,
    input  logic [hsvg_pkg::HUE_W-1:0]    hue_degrees,
    input  logic [hsvg_pkg::CHAN_W-1:0]   saturation_level,
    input  logic [hsvg_pkg::CHAN_W-1:0]   brightness_level,
    output logic                          done,
    output logic [hsvg_pkg::INDEX_W-1:0]  pixel_index_out,
    output logic                          written,
    output logic [hsvg_pkg::CHAN_W-1:0]   red_level,
    output logic [hsvg_pkg::GREEN_W-1:0]  green_level,
    output logic [hsvg_pkg::CHAN_W-1:0]   blue_level
);
    import hsvg_pkg::*;

    localparam int unsigned DEPTH = 6;
    localparam logic [INDEX_W:0] STRIP_LIMIT = (INDEX_W + 1)'(STRIP_LENGTH);

    // The pipeline has no back pressure, so a request is never refused.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits, one per stage.
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    assign valid_next = {valid_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ---------------- Stage 1: hue split, v*(255-s), range check ----------------
    logic [INDEX_W-1:0]  s1_index_reg;
    logic                s1_wr_reg;
    logic [CHAN_W-1:0]   s1_v_reg;
    logic [SECTOR_W-1:0] s1_sector_reg;
    logic [OFFSET_W-1:0] s1_off_reg;
    logic [15:0]         s1_prod_reg;

    logic [SECTOR_W-1:0] s1_sector_next;
    logic [OFFSET_W-1:0] s1_off_next;
    logic [15:0]         s1_prod_next;
    logic                s1_wr_next;
    logic [HUE_W-1:0]    s1_base;

    always_comb
    begin
        s1_sector_next = hue_sector(hue_degrees);
        s1_base        = HUE_W'(s1_sector_next) * HUE_W'(SECTOR_SPAN);
        s1_off_next    = OFFSET_W'(hue_degrees - s1_base);
        s1_prod_next   = 16'(brightness_level)
                         * (16'(CHAN_MAX) - 16'(saturation_level));
        s1_wr_next     = {1'b0, pixel_index} < STRIP_LIMIT;
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg  <= pixel_index;
        s1_wr_reg     <= s1_wr_next;
        s1_v_reg      <= brightness_level;
        s1_sector_reg <= s1_sector_next;
        s1_off_reg    <= s1_off_next;
        s1_prod_reg   <= s1_prod_next;
    end

    // ---------------- Stage 2: min = floor(prod / 255) ----------------
    // For x below 65535, floor(x/255) = (x + (x >> 8) + 1) >> 8.
    logic [INDEX_W-1:0]  s2_index_reg;
    logic                s2_wr_reg;
    logic [CHAN_W-1:0]   s2_v_reg;
    logic [SECTOR_W-1:0] s2_sector_reg;
    logic [OFFSET_W-1:0] s2_off_reg;
    logic [CHAN_W-1:0]   s2_lo_reg;

    logic [16:0]         s2_sum;
    logic [CHAN_W-1:0]   s2_lo_next;

    always_comb
    begin
        s2_sum     = {1'b0, s1_prod_reg} + 17'(s1_prod_reg[15:8]) + 17'd1;
        s2_lo_next = s2_sum[15:8];
    end

    always_ff @(posedge clk)
    begin
        s2_index_reg  <= s1_index_reg;
        s2_wr_reg     <= s1_wr_reg;
        s2_v_reg      <= s1_v_reg;
        s2_sector_reg <= s1_sector_reg;
        s2_off_reg    <= s1_off_reg;
        s2_lo_reg     <= s2_lo_next;
    end

    // ---------------- Stage 3: (v - min) * offset ----------------
    logic [INDEX_W-1:0]  s3_index_reg;
    logic                s3_wr_reg;
    logic [CHAN_W-1:0]   s3_v_reg;
    logic [SECTOR_W-1:0] s3_sector_reg;
    logic [CHAN_W-1:0]   s3_lo_reg;
    logic [13:0]         s3_prod_reg;

    logic [CHAN_W-1:0]   s3_diff;
    logic [13:0]         s3_prod_next;

    always_comb
    begin
        s3_diff      = s2_v_reg - s2_lo_reg;
        s3_prod_next = 14'(s3_diff) * 14'(s2_off_reg);
    end

    always_ff @(posedge clk)
    begin
        s3_index_reg  <= s2_index_reg;
        s3_wr_reg     <= s2_wr_reg;
        s3_v_reg      <= s2_v_reg;
        s3_sector_reg <= s2_sector_reg;
        s3_lo_reg     <= s2_lo_reg;
        s3_prod_reg   <= s3_prod_next;
    end

    // ---------------- Stage 4: adj = floor(prod / 60) ----------------
    // Divide by 4 with a shift, then by 15 with a reciprocal multiply.
    logic [INDEX_W-1:0]  s4_index_reg;
    logic                s4_wr_reg;
    logic [CHAN_W-1:0]   s4_v_reg;
    logic [SECTOR_W-1:0] s4_sector_reg;
    logic [CHAN_W-1:0]   s4_lo_reg;
    logic [CHAN_W-1:0]   s4_adj_reg;

    logic [23:0]         s4_mul;
    logic [CHAN_W-1:0]   s4_adj_next;

    always_comb
    begin
        s4_mul      = 24'(s3_prod_reg[13:2]) * 24'(RECIP15_MUL);
        s4_adj_next = s4_mul[RECIP15_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        s4_index_reg  <= s3_index_reg;
        s4_wr_reg     <= s3_wr_reg;
        s4_v_reg      <= s3_v_reg;
        s4_sector_reg <= s3_sector_reg;
        s4_lo_reg     <= s3_lo_reg;
        s4_adj_reg    <= s4_adj_next;
    end

    // ---------------- Stage 5: sector select ----------------
    logic [INDEX_W-1:0] s5_index_reg;
    logic               s5_wr_reg;
    logic [CHAN_W-1:0]  s5_r_reg;
    logic [CHAN_W-1:0]  s5_g_reg;
    logic [CHAN_W-1:0]  s5_b_reg;

    logic [CHAN_W-1:0]  s5_up;
    logic [CHAN_W-1:0]  s5_dn;
    logic [CHAN_W-1:0]  s5_r_next;
    logic [CHAN_W-1:0]  s5_g_next;
    logic [CHAN_W-1:0]  s5_b_next;

    always_comb
    begin
        s5_up = s4_lo_reg + s4_adj_reg;
        s5_dn = s4_v_reg - s4_adj_reg;
        // Sector five and any hue above 359 share the last case.
        unique case (s4_sector_reg)
            SEC_RED_UP:
            begin
                s5_r_next = s4_v_reg;  s5_g_next = s5_up;     s5_b_next = s4_lo_reg;
            end
            SEC_GREEN_DN:
            begin
                s5_r_next = s5_dn;     s5_g_next = s4_v_reg;  s5_b_next = s4_lo_reg;
            end
            SEC_GREEN_UP:
            begin
                s5_r_next = s4_lo_reg; s5_g_next = s4_v_reg;  s5_b_next = s5_up;
            end
            SEC_BLUE_DN:
            begin
                s5_r_next = s4_lo_reg; s5_g_next = s5_dn;     s5_b_next = s4_v_reg;
            end
            SEC_BLUE_UP:
            begin
                s5_r_next = s5_up;     s5_g_next = s4_lo_reg; s5_b_next = s4_v_reg;
            end
            default:
            begin
                s5_r_next = s4_v_reg;  s5_g_next = s4_lo_reg; s5_b_next = s5_dn;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s5_index_reg <= s4_index_reg;
        s5_wr_reg    <= s4_wr_reg;
        s5_r_reg     <= s5_r_next;
        s5_g_reg     <= s5_g_next;
        s5_b_reg     <= s5_b_next;
    end

    // ---------------- Stage 6: channel gains and output ----------------
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_wr_reg;
    logic [CHAN_W-1:0]  out_r_reg;
    logic [GREEN_W-1:0] out_g_reg;
    logic [CHAN_W-1:0]  out_b_reg;

    logic [9:0]         s6_r3;
    logic [9:0]         s6_g2;
    logic [19:0]        s6_rmul;
    logic [19:0]        s6_gmul;
    logic [CHAN_W-1:0]  out_r_next;
    logic [GREEN_W-1:0] out_g_next;
    logic [CHAN_W-1:0]  out_b_next;

    always_comb
    begin
        s6_r3   = 10'(s5_r_reg) * 10'd3;
        s6_g2   = {1'b0, s5_g_reg, 1'b0};
        s6_rmul = 20'(s6_r3) * 20'(RECIP5_MUL);
        s6_gmul = 20'(s6_g2) * 20'(RECIP5_MUL);
        if (s5_wr_reg)
        begin
            out_r_next = s6_rmul[RECIP5_SHIFT +: CHAN_W];
            out_g_next = s6_gmul[RECIP5_SHIFT +: GREEN_W];
            out_b_next = s5_b_reg;
        end
        else
        begin
            out_r_next = '0;
            out_g_next = '0;
            out_b_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= s5_index_reg;
        out_wr_reg    <= s5_wr_reg;
        out_r_reg     <= out_r_next;
        out_g_reg     <= out_g_next;
        out_b_reg     <= out_b_next;
    end

    assign done            = valid_reg[DEPTH-1];
    assign pixel_index_out = out_index_reg;
    assign written         = out_wr_reg;
    assign red_level       = out_r_reg;
    assign green_level     = out_g_reg;
    assign blue_level      = out_b_reg;

    // ---------------- Assertions ----------------
    // Every accepted request produces its result beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##DEPTH done)
        else $error("result beat missing after a request");

    // A result beat never appears without a matching earlier request.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, DEPTH))
        else $error("result beat without a request");

    // Dropped pixels carry zero color levels.
    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !written) |-> (red_level == '0 && green_level == '0 && blue_level == '0))
        else $error("dropped pixel has nonzero levels");

    // The written flag follows the strip length of the index that came out.
    a_written_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (written == ({1'b0, pixel_index_out} < STRIP_LIMIT)))
        else $error("written flag does not match the index");

    // Red gain of 3/5 keeps red at or below 153.
    a_red_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red_level <= CHAN_W'(153)))
        else $error("red level above its gain limit");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the HSV to RGB pixel gain unit.
module tb_top;
    import hsvg_pkg::*;

    // The strip length used by the instance and by the predictor.
    localparam int unsigned STRIP_LEN = STRIP_LENGTH_DEFAULT;

    // The pipeline latency, and a settling time after the last expected result
    // has come back.
    localparam int unsigned PIPE_LATENCY = 6;
    localparam int unsigned SETTLE_CYCLES = 4 * PIPE_LATENCY;

    // Random requests per idling phase. Four phases give roughly 1750
    // requests in all, together with the directed opening set.
    localparam int unsigned RANDOM_PER_PHASE = 435;
    localparam int unsigned PHASE_COUNT = 4;

    // A correct run ends well before this limit, which is given in time units.
    localparam int unsigned RUN_LIMIT = 4_000_000;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [HUE_W-1:0]   hue;
        logic [CHAN_W-1:0]  sat;
        logic [CHAN_W-1:0]  val;
    } pixel_request_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               written;
        logic [CHAN_W-1:0]  red;
        logic [GREEN_W-1:0] green;
        logic [CHAN_W-1:0]  blue;
    } pixel_levels_t;

    // Every input is known from time zero. Start stays low through reset.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [INDEX_W-1:0] pixel_index = '0;
    logic [HUE_W-1:0]   hue_degrees = '0;
    logic [CHAN_W-1:0]  saturation_level = '0;
    logic [CHAN_W-1:0]  brightness_level = '0;
    logic               done;
    logic [INDEX_W-1:0] pixel_index_out;
    logic               written;
    logic [CHAN_W-1:0]  red_level;
    logic [GREEN_W-1:0] green_level;
    logic [CHAN_W-1:0]  blue_level;

    // Requests that the stimulus block has queued but the driver has not yet
    // put on the bus, and the levels predicted for accepted request beats.
    pixel_request_t pending_requests[$];
    pixel_levels_t  expected_levels[$];

    // Chance, in percent, that the driver leaves a cycle empty.
    int unsigned sender_idle_pct = 0;
    int unsigned mismatch_count = 0;

    hsv_to_rgb_pixel_gain_unit #(
        .STRIP_LENGTH(STRIP_LEN)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pixel_index      (pixel_index),
        .hue_degrees      (hue_degrees),
        .saturation_level (saturation_level),
        .brightness_level (brightness_level),
        .done             (done),
        .pixel_index_out  (pixel_index_out),
        .written          (written),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Integer six-sector conversion followed by the fixed channel gains.
    // A request outside the strip is dropped: only its index comes back.
    function automatic pixel_levels_t predict_levels(pixel_request_t req);
        pixel_levels_t       lv;
        int unsigned         v;
        int unsigned         lo;
        int unsigned         off;
        int unsigned         adj;
        int unsigned         up;
        int unsigned         dn;
        int unsigned         r;
        int unsigned         g;
        int unsigned         b;
        logic [SECTOR_W-1:0] sector;
        lv = '0;
        lv.index = req.index;
        if (req.index < STRIP_LEN)
        begin
            v = req.val;
            lo = (v * (CHAN_MAX - req.sat)) / CHAN_MAX;
            sector = SECTOR_W'(req.hue / SECTOR_SPAN);
            off = req.hue % SECTOR_SPAN;
            adj = ((v - lo) * off) / SECTOR_SPAN;
            up = lo + adj;
            dn = v - adj;
            // Hues above 359 land in sectors 6 to 8 and share the last case.
            case (sector)
                SEC_RED_UP:   begin r = v;  g = up; b = lo; end
                SEC_GREEN_DN: begin r = dn; g = v;  b = lo; end
                SEC_GREEN_UP: begin r = lo; g = v;  b = up; end
                SEC_BLUE_DN:  begin r = lo; g = dn; b = v;  end
                SEC_BLUE_UP:  begin r = up; g = lo; b = v;  end
                default:      begin r = v;  g = lo; b = dn; end
            endcase
            lv.written = 1'b1;
            lv.red = CHAN_W'((r * 3) / 5);
            lv.green = GREEN_W'((g * 2) / 5);
            lv.blue = CHAN_W'(b);
        end
        return lv;
    endfunction

    function automatic pixel_request_t make_request(int unsigned idx, int unsigned hue,
                                                    int unsigned sat, int unsigned val);
        pixel_request_t req;
        req.index = INDEX_W'(idx);
        req.hue = HUE_W'(hue);
        req.sat = CHAN_W'(sat);
        req.val = CHAN_W'(val);
        return req;
    endfunction

    // Most random requests address the strip with a legal hue. The rest hit
    // the strip boundary, indexes anywhere in the 16-bit range, hues on a
    // sector edge, hues above 359, and saturation or value at the extremes.
    function automatic pixel_request_t random_request();
        pixel_request_t req;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 70)
            req.index = INDEX_W'($urandom_range(STRIP_LEN - 1, 0));
        else if (pick < 78)
            req.index = INDEX_W'($urandom_range(1) ? STRIP_LEN - 1 : STRIP_LEN);
        else
            req.index = INDEX_W'($urandom);

        pick = $urandom_range(99);
        if (pick < 10)
            req.hue = HUE_W'($urandom_range(511, 360));
        else if (pick < 20)
            req.hue = HUE_W'($urandom_range(5) * SECTOR_SPAN + ($urandom_range(1) ? 0 : 59));
        else
            req.hue = HUE_W'($urandom_range(359, 0));

        pick = $urandom_range(99);
        req.sat = (pick < 8) ? '0 : (pick < 16) ? '1 : CHAN_W'($urandom);
        pick = $urandom_range(99);
        req.val = (pick < 8) ? '0 : (pick < 16) ? '1 : CHAN_W'($urandom);
        return req;
    endfunction

    // Driver. A request beat is taken at an edge where start is high and busy
    // is low; the ports still hold that beat's values when this block runs,
    // so the prediction is made from them directly. Once the bus is free the
    // driver either presents the next queued request or idles, and while
    // idle it scrambles the payload ports so that the unit must ignore them.
    always @(posedge clk)
    begin : request_driver
        pixel_request_t taken;
        pixel_request_t next_req;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken.index = pixel_index;
                taken.hue = hue_degrees;
                taken.sat = saturation_level;
                taken.val = brightness_level;
                expected_levels.push_back(predict_levels(taken));
            end
            if (!start || !busy)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    start <= 1'b1;
                    pixel_index <= next_req.index;
                    hue_degrees <= next_req.hue;
                    saturation_level <= next_req.sat;
                    brightness_level <= next_req.val;
                end
                else
                begin
                    start <= 1'b0;
                    pixel_index <= INDEX_W'($urandom);
                    hue_degrees <= HUE_W'($urandom);
                    saturation_level <= CHAN_W'($urandom);
                    brightness_level <= CHAN_W'($urandom);
                end
            end
        end
    end

    // Monitor. A result beat is on the ports for exactly one cycle with done
    // high, and is taken at the edge that ends that cycle. Each beat is
    // checked field by field against the oldest prediction.
    always @(posedge clk)
    begin : level_monitor
        pixel_levels_t want;
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                $display("%0t: done is unknown", $time);
                mismatch_count++;
            end
            else if (done)
            begin
                if (expected_levels.size() == 0)
                begin
                    $display("%0t: result beat with no request waiting, index %0d",
                             $time, pixel_index_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (pixel_index_out !== want.index)
                    begin
                        $display("%0t: pixel_index_out expected %0d actual %0d",
                                 $time, want.index, pixel_index_out);
                        mismatch_count++;
                    end
                    if (written !== want.written)
                    begin
                        $display("%0t: written expected %0d actual %0d (index %0d)",
                                 $time, want.written, written, want.index);
                        mismatch_count++;
                    end
                    if (red_level !== want.red)
                    begin
                        $display("%0t: red_level expected %0d actual %0d (index %0d)",
                                 $time, want.red, red_level, want.index);
                        mismatch_count++;
                    end
                    if (green_level !== want.green)
                    begin
                        $display("%0t: green_level expected %0d actual %0d (index %0d)",
                                 $time, want.green, green_level, want.index);
                        mismatch_count++;
                    end
                    if (blue_level !== want.blue)
                    begin
                        $display("%0t: blue_level expected %0d actual %0d (index %0d)",
                                 $time, want.blue, blue_level, want.index);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Stimulus. The queue is filled one phase at a time, and between phases
    // the sender holds off until every predicted result has come back.
    initial
    begin : stimulus
        int unsigned phase_idle_pct[PHASE_COUNT];
        phase_idle_pct = '{0, 78, 0, 16};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening set: each sector at both ends of its offset range,
        // hues above 359, zero saturation, zero and full value, the last
        // index on the strip, the first one off it, and the largest index.
        pending_requests.push_back(make_request(0, 0, 255, 255));
        pending_requests.push_back(make_request(1, 59, 255, 255));
        pending_requests.push_back(make_request(2, 60, 255, 255));
        pending_requests.push_back(make_request(3, 119, 255, 255));
        pending_requests.push_back(make_request(4, 120, 255, 255));
        pending_requests.push_back(make_request(5, 179, 200, 255));
        pending_requests.push_back(make_request(6, 180, 255, 255));
        pending_requests.push_back(make_request(7, 239, 128, 200));
        pending_requests.push_back(make_request(8, 240, 255, 255));
        pending_requests.push_back(make_request(9, 299, 255, 255));
        pending_requests.push_back(make_request(10, 300, 255, 255));
        pending_requests.push_back(make_request(11, 359, 255, 255));
        pending_requests.push_back(make_request(12, 360, 255, 255));
        pending_requests.push_back(make_request(13, 420, 100, 200));
        pending_requests.push_back(make_request(14, 511, 255, 255));
        pending_requests.push_back(make_request(15, 200, 0, 180));
        pending_requests.push_back(make_request(16, 90, 0, 0));
        pending_requests.push_back(make_request(40, 150, 255, 0));
        pending_requests.push_back(make_request(20, 45, 1, 254));
        pending_requests.push_back(make_request(STRIP_LEN - 1, 30, 255, 255));
        pending_requests.push_back(make_request(STRIP_LEN, 30, 255, 255));
        pending_requests.push_back(make_request(65535, 511, 255, 255));

        for (int p = 0; p <= PHASE_COUNT; p++)
        begin
            // Hold off until the queue is empty, the bus is idle and every
            // prediction has been matched by a result beat.
            do
                @(negedge clk);
            while (pending_requests.size() != 0 || start || expected_levels.size() != 0);
            if (p < PHASE_COUNT)
            begin
                sender_idle_pct = phase_idle_pct[p];
                for (int n = 0; n < RANDOM_PER_PHASE; n++)
                    pending_requests.push_back(random_request());
            end
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("hsv_to_rgb_pixel_gain_unit regression: pass");
        else
            $display("hsv_to_rgb_pixel_gain_unit regression: fail");
        $finish;
    end

    // A run that has not ended by now is stuck.
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("hsv_to_rgb_pixel_gain_unit regression: fail");
        $finish;
    end

endmodule
